// ===== design/tcmag_pkg.sv =====
// Shared types and constants of the tiled convolution / matmul address generator.
// No dependencies; every other design file refers to this package by scoped names.
package tcmag_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int DIM_BITS      = 8;
    localparam int CFG_BITS      = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int WORD_BITS     = 30;
    localparam int EN_BITS       = 4;
    localparam int DIV_BITS      = 18;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_A    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_B    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_C    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NULL_ADDR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_MODE = 3'd6;

    localparam logic [1:0] MODE_CONV = 2'd0;
    localparam logic [1:0] MODE_PW   = 2'd1;
    localparam logic [1:0] MODE_DW   = 2'd2;
    localparam logic [1:0] MODE_MM   = 2'd3;

    typedef struct packed {
        logic [31:0] base_a;
        logic [31:0] base_b;
        logic [31:0] base_c;
        logic [31:0] null_addr;
        logic [31:0] dims;
        logic [31:0] kernel;
        logic [30:0] tile_mode;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
        logic [DIV_BITS-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATCH,
        ST_SIZE,
        ST_TICK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_EMIT
    } t_state;

endpackage

// ===== design/tcmag_if.sv =====
// Valid/ready channel interfaces for the command input and the address result output.
// Depends on tcmag_pkg for the payload widths.
interface tcmag_cmd_if;
    logic valid;
    logic ready;
    logic command;
    logic clear_offset;

    modport source (output valid, command, clear_offset, input ready);
    modport sink   (input valid, command, clear_offset, output ready);
endinterface

interface tcmag_res_if;
    logic                                valid;
    logic                                ready;
    logic [tcmag_pkg::WORD_BITS-1:0]     word_addr_a;
    logic [tcmag_pkg::EN_BITS-1:0]       enable_a;
    logic [tcmag_pkg::WORD_BITS-1:0]     word_addr_b;
    logic [tcmag_pkg::EN_BITS-1:0]       enable_b;
    logic [tcmag_pkg::WORD_BITS-1:0]     word_addr_c;
    logic [tcmag_pkg::EN_BITS-1:0]       enable_c;
    logic                                running;
    logic                                last_k_tile;
    logic                                layer_finished;

    modport source (output valid, word_addr_a, enable_a, word_addr_b, enable_b,
                    word_addr_c, enable_c, running, last_k_tile, layer_finished,
                    input ready);
    modport sink   (input valid, word_addr_a, enable_a, word_addr_b, enable_b,
                    word_addr_c, enable_c, running, last_k_tile, layer_finished,
                    output ready);
endinterface

// ===== design/tcmag_front.sv =====
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
// Depends on tcmag_pkg and tcmag_cmd_if.
module tcmag_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcmag_cmd_if.sink          i_cmd,
    output tcmag_pkg::t_cmd    o_item,
    output logic               o_item_valid,
    input  logic               i_item_pop
);

    tcmag_pkg::t_cmd r_q [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;

    assign i_cmd.ready  = (r_cnt != 2'd2);
    assign push         = i_cmd.valid && i_cmd.ready;
    assign pop          = i_item_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr].start <= i_cmd.command;
                r_q[r_wr].clear <= i_cmd.clear_offset;
                r_wr            <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/tcmag_div.sv =====
// Iterative restoring divider, one quotient bit per cycle; a zero divisor gives zero results.
// Depends on tcmag_pkg for the request and response structs.
module tcmag_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcmag_pkg::t_div_req   i_req,
    output tcmag_pkg::t_div_rsp   o_rsp
);

    localparam int DB = tcmag_pkg::DIV_BITS;
    localparam int CB = $clog2(DB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CB-1:0] r_cnt;
    logic [DB-1:0] r_quot;
    logic [DB-1:0] r_rem;
    logic [DB-1:0] r_den;
    logic          r_zero;
    logic [DB:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quot[DB-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(DB);
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_zero <= (i_req.divisor == '0);
            end else if (r_busy) begin
                r_rem  <= fits ? DB'(trial - {1'b0, r_den}) : DB'(trial);
                r_quot <= {r_quot[DB-2:0], fits};
                r_cnt  <= r_cnt - CB'(1);
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_zero ? '0 : r_quot;
    assign o_rsp.rem  = r_zero ? '0 : r_rem;

endmodule

// ===== design/tcmag_back.sv =====
// Back end: layer sequencer, six-deep tile walk, address arithmetic and output register.
// Depends on tcmag_pkg, tcmag_res_if and an external tcmag_div unit.
module tcmag_back #(
    parameter int ADDR_BITS = tcmag_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcmag_pkg::t_cfg      i_cfg,
    input  tcmag_pkg::t_cmd      i_item,
    input  logic                 i_item_valid,
    output logic                 o_item_pop,
    output tcmag_pkg::t_div_req  o_div_req,
    input  tcmag_pkg::t_div_rsp  i_div_rsp,
    tcmag_res_if.source          o_res
);

    localparam int AW = ADDR_BITS;
    localparam int EW = (AW > 32) ? AW : 32;
    localparam int DB = tcmag_pkg::DIV_BITS;

    localparam logic [1:0] DSTEP_ROW = 2'd0;
    localparam logic [1:0] DSTEP_KB  = 2'd1;
    localparam logic [1:0] DSTEP_KW  = 2'd2;
    localparam logic [1:0] DSTEP_CH  = 2'd3;

    tcmag_pkg::t_state r_state, n_state;

    // latched layer
    logic [31:0] r_la, r_lb, r_lc, r_lnull;
    logic [7:0]  r_cin, r_w, r_h, r_tm, r_tn, r_tk;
    logic [2:0]  r_kw;
    logic [1:0]  r_pad, r_stride, r_mode;
    logic [5:0]  r_kb;
    logic [10:0] r_ks;
    logic        r_clear;

    // walk state
    logic          r_active;
    logic [9:0]    r_ow, r_ho, r_cols;
    logic [17:0]   r_rows;
    logic [14:0]   r_depth;
    logic [17:0]   r_tbm;
    logic [9:0]    r_tbn;
    logic [14:0]   r_tbk;
    logic [7:0]    r_im, r_in, r_ik;
    logic [AW-1:0] r_coff;

    // per-tick work
    logic          r_idle;
    logic [17:0]   r_ig;
    logic [9:0]    r_jg;
    logic [14:0]   r_kg;
    logic          r_last, r_aok, r_bok, r_cok;
    logic [1:0]    r_dstep;
    logic [DB-1:0] r_qh, r_rh, r_q2, r_r2, r_q3, r_r3, r_r4;
    logic [7:0]    r_ih, r_iw;
    logic          r_inb;
    logic [DB-1:0] r_ch;
    logic [27:0]   r_pc, r_mn;
    logic [24:0]   r_pb;
    logic [15:0]   r_pam, r_pbm, r_jkb, r_t;
    logic [24:0]   r_u;

    // output register
    logic                            r_out_valid;
    logic [tcmag_pkg::WORD_BITS-1:0] r_wa, r_wb, r_wc;
    logic [tcmag_pkg::EN_BITS-1:0]   r_ea, r_eb, r_ec;
    logic                            r_run, r_lastk, r_fin;

    function automatic logic [9:0] out_size(input logic [7:0] in_sz, input logic [2:0] kern,
                                            input logic [1:0] pad, input logic [1:0] s);
        logic [8:0]  padded;
        logic [8:0]  diff;
        logic [19:0] prod;
        logic [8:0]  q;
        padded = {1'b0, in_sz} + {6'b0, pad, 1'b0};
        diff   = padded - {6'b0, kern};
        prod   = 20'(diff) * 20'd683;
        case (s)
            2'd2:    q = diff >> 1;
            2'd3:    q = prod[19:11];
            default: q = diff;
        endcase
        if (padded < {6'b0, kern}) begin
            return 10'd0;
        end
        return {1'b0, q} + 10'd1;
    endfunction

    function automatic logic [tcmag_pkg::WORD_BITS-1:0] word_of(input logic [AW-1:0] byte_addr);
        logic [EW-1:0] ext;
        ext = EW'(byte_addr);
        return ext[31:2];
    endfunction

    function automatic logic [tcmag_pkg::EN_BITS-1:0] en_of(input logic [AW-1:0] byte_addr);
        return tcmag_pkg::EN_BITS'(1) << byte_addr[1:0];
    endfunction

    // layer sizes from the configuration
    logic [1:0]  c_mode, c_pad, c_stride, c_s;
    logic [2:0]  c_kh, c_kw, c_keh, c_kew;
    logic [7:0]  c_cin, c_w, c_h, c_cout;
    assign c_mode   = i_cfg.tile_mode[29:28];
    assign c_pad    = i_cfg.tile_mode[27:26];
    assign c_stride = i_cfg.tile_mode[25:24];
    assign c_s      = (c_stride == 2'd0) ? 2'd1 : c_stride;
    assign c_kh     = i_cfg.kernel[29:27];
    assign c_kw     = i_cfg.kernel[26:24];
    assign c_keh    = (c_mode == tcmag_pkg::MODE_PW) ? 3'd1 : c_kh;
    assign c_kew    = (c_mode == tcmag_pkg::MODE_PW) ? 3'd1 : c_kw;
    assign c_cout   = i_cfg.dims[31:24];
    assign c_cin    = i_cfg.dims[23:16];
    assign c_w      = i_cfg.dims[15:8];
    assign c_h      = i_cfg.dims[7:0];

    // tick operands
    logic [17:0] t_ig;
    logic [9:0]  t_jg;
    logic [14:0] t_kg;
    assign t_ig = r_tbm + 18'(r_im);
    assign t_jg = r_tbn + 10'(r_in);
    assign t_kg = r_tbk + 15'(r_ik);

    // window offsets per mode
    logic [DB-1:0] m_dh, m_dw, m_ch;
    logic [21:0]   m_ih, m_iw;
    always_comb begin
        case (r_mode)
            tcmag_pkg::MODE_DW: begin
                m_dh = r_q3; m_dw = r_r3; m_ch = r_q2;
            end
            tcmag_pkg::MODE_PW: begin
                m_dh = '0; m_dw = '0; m_ch = DB'(r_kg);
            end
            default: begin
                m_dh = r_q2; m_dw = r_q3; m_ch = r_r4;
            end
        endcase
        m_ih = 22'(r_qh) * 22'(r_stride) + 22'(m_dh) - 22'(r_pad);
        m_iw = 22'(r_rh) * 22'(r_stride) + 22'(m_dw) - 22'(r_pad);
    end

    // divider operands
    always_comb begin
        o_div_req.start = (r_state == tcmag_pkg::ST_DIV_GO);
        case (r_dstep)
            DSTEP_ROW: begin
                o_div_req.dividend = r_ig;
                o_div_req.divisor  = DB'(r_ow);
            end
            DSTEP_KB: begin
                o_div_req.dividend = DB'(r_kg);
                o_div_req.divisor  = (r_mode == tcmag_pkg::MODE_DW) ? DB'(r_kb) : DB'(r_ks);
            end
            DSTEP_KW: begin
                o_div_req.dividend = r_r2;
                o_div_req.divisor  = (r_mode == tcmag_pkg::MODE_DW) ? DB'(r_kw) : DB'(r_cin);
            end
            default: begin
                o_div_req.dividend = DB'(r_kg);
                o_div_req.divisor  = DB'(r_cin);
            end
        endcase
    end

    // final byte addresses
    logic [AW-1:0] e_null, e_a, e_b, e_c;
    logic [16:0]   e_lo, e_hi;
    always_comb begin
        e_null = AW'(r_lnull);
        e_lo   = 17'(r_jkb);
        e_hi   = 17'(r_jkb) + 17'(r_kb);
        if (r_idle) begin
            e_a = AW'(i_cfg.null_addr);
            e_b = AW'(i_cfg.null_addr);
            e_c = AW'(i_cfg.null_addr);
        end else begin
            if (!r_aok) begin
                e_a = e_null;
            end else if (r_mode == tcmag_pkg::MODE_MM) begin
                e_a = AW'(r_la) + AW'(r_pam) + AW'(r_ik);
            end else if (r_ow != 10'd0 && r_inb) begin
                e_a = AW'(r_la) + AW'(r_u);
            end else begin
                e_a = e_null;
            end
            if (!r_bok) begin
                e_b = e_null;
            end else if (r_mode == tcmag_pkg::MODE_MM) begin
                e_b = AW'(r_lb) + AW'(r_pbm) + AW'(r_in);
            end else if (r_mode == tcmag_pkg::MODE_DW) begin
                e_b = (17'(r_kg) >= e_lo && 17'(r_kg) < e_hi) ? AW'(r_lb) + AW'(r_kg) : e_null;
            end else begin
                e_b = AW'(r_lb) + AW'(r_pb) + AW'(r_kg);
            end
            e_c = r_cok ? AW'(r_lc) + r_coff + AW'(r_pc) + AW'(r_jg) : e_null;
        end
    end

    // six-deep loop advance
    logic [7:0]  n_im, n_in, n_ik;
    logic [17:0] n_tbm;
    logic [9:0]  n_tbn;
    logic [14:0] n_tbk;
    logic        n_done;
    logic [8:0]  a_k, a_n, a_m;
    logic [15:0] a_tk;
    logic [10:0] a_tn;
    logic [18:0] a_tm;
    always_comb begin
        a_k  = {1'b0, r_ik} + 9'd1;
        a_n  = {1'b0, r_in} + 9'd1;
        a_m  = {1'b0, r_im} + 9'd1;
        a_tk = {1'b0, r_tbk} + 16'(r_tk);
        a_tn = {1'b0, r_tbn} + 11'(r_tn);
        a_tm = {1'b0, r_tbm} + 19'(r_tm);
        n_im = r_im; n_in = r_in; n_ik = r_ik;
        n_tbm = r_tbm; n_tbn = r_tbn; n_tbk = r_tbk;
        n_done = 1'b0;
        if (a_k < {1'b0, r_tk}) begin
            n_ik = a_k[7:0];
        end else begin
            n_ik = '0;
            if (a_n < {1'b0, r_tn}) begin
                n_in = a_n[7:0];
            end else begin
                n_in = '0;
                if (a_m < {1'b0, r_tm}) begin
                    n_im = a_m[7:0];
                end else begin
                    n_im = '0;
                    if (a_tk < 16'(r_depth)) begin
                        n_tbk = a_tk[14:0];
                    end else begin
                        n_tbk = '0;
                        if (a_tn < 11'(r_cols)) begin
                            n_tbn = a_tn[9:0];
                        end else begin
                            n_tbn = '0;
                            if (a_tm < 19'(r_rows)) begin
                                n_tbm = a_tm[17:0];
                            end else begin
                                n_tbm  = a_tm[17:0];
                                n_done = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    logic emit_ok;
    logic emit_fire;
    assign emit_ok   = !r_out_valid || o_res.ready;
    assign emit_fire = (r_state == tcmag_pkg::ST_EMIT) && emit_ok;

    // next state and queue pop
    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        case (r_state)
            tcmag_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_state    = i_item.start ? tcmag_pkg::ST_LATCH : tcmag_pkg::ST_TICK;
                end
            end
            tcmag_pkg::ST_LATCH:  n_state = tcmag_pkg::ST_SIZE;
            tcmag_pkg::ST_SIZE:   n_state = tcmag_pkg::ST_TICK;
            tcmag_pkg::ST_TICK:   n_state = r_active ? tcmag_pkg::ST_DIV_GO : tcmag_pkg::ST_EMIT;
            tcmag_pkg::ST_DIV_GO: n_state = tcmag_pkg::ST_DIV_WAIT;
            tcmag_pkg::ST_DIV_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = (r_dstep == DSTEP_CH) ? tcmag_pkg::ST_MUL1 : tcmag_pkg::ST_DIV_GO;
                end
            end
            tcmag_pkg::ST_MUL1:   n_state = tcmag_pkg::ST_MUL2;
            tcmag_pkg::ST_MUL2:   n_state = tcmag_pkg::ST_MUL3;
            tcmag_pkg::ST_MUL3:   n_state = tcmag_pkg::ST_EMIT;
            tcmag_pkg::ST_EMIT: begin
                if (emit_ok) begin
                    n_state = tcmag_pkg::ST_IDLE;
                end
            end
            default:              n_state = tcmag_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcmag_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_coff      <= '0;
            r_dstep     <= DSTEP_ROW;
            r_ow        <= '0;
            r_rows      <= '0;
            r_cols      <= '0;
            r_depth     <= '0;
            r_tbm       <= '0;
            r_tbn       <= '0;
            r_tbk       <= '0;
            r_im        <= '0;
            r_in        <= '0;
            r_ik        <= '0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                tcmag_pkg::ST_IDLE: begin
                    if (i_item_valid) begin
                        r_clear <= i_item.clear;
                    end
                end
                tcmag_pkg::ST_LATCH: begin
                    r_la     <= i_cfg.base_a;
                    r_lb     <= i_cfg.base_b;
                    r_lc     <= i_cfg.base_c;
                    r_lnull  <= i_cfg.null_addr;
                    r_cin    <= c_cin;
                    r_w      <= c_w;
                    r_h      <= c_h;
                    r_kw     <= c_kw;
                    r_mode   <= c_mode;
                    r_pad    <= c_pad;
                    r_stride <= c_stride;
                    r_tm     <= i_cfg.tile_mode[23:16];
                    r_tn     <= i_cfg.tile_mode[15:8];
                    r_tk     <= i_cfg.tile_mode[7:0];
                    r_kb     <= 6'(c_kh) * 6'(c_kw);
                    r_ks     <= 11'(c_kw) * 11'(c_cin);
                    r_ho     <= out_size(c_h, c_keh, c_pad, c_s);
                    r_ow     <= (c_mode == tcmag_pkg::MODE_MM) ? 10'd0
                                : out_size(c_w, c_kew, c_pad, c_s);
                    if (r_clear) begin
                        r_coff <= '0;
                    end
                end
                tcmag_pkg::ST_SIZE: begin
                    case (r_mode)
                        tcmag_pkg::MODE_MM: begin
                            r_rows  <= 18'(i_cfg.kernel[8:0]);
                            r_cols  <= 10'(i_cfg.kernel[17:9]);
                            r_depth <= 15'(i_cfg.kernel[26:18]);
                        end
                        tcmag_pkg::MODE_PW: begin
                            r_rows  <= 18'(r_ho) * 18'(r_ow);
                            r_cols  <= 10'(c_cout);
                            r_depth <= 15'(r_cin);
                        end
                        tcmag_pkg::MODE_DW: begin
                            r_rows  <= 18'(r_ho) * 18'(r_ow);
                            r_cols  <= 10'(r_cin);
                            r_depth <= 15'(r_kb) * 15'(r_cin);
                        end
                        default: begin
                            r_rows  <= 18'(r_ho) * 18'(r_ow);
                            r_cols  <= 10'(c_cout);
                            r_depth <= 15'(r_kb) * 15'(r_cin);
                        end
                    endcase
                    r_tbm    <= '0;
                    r_tbn    <= '0;
                    r_tbk    <= '0;
                    r_im     <= '0;
                    r_in     <= '0;
                    r_ik     <= '0;
                    r_active <= 1'b1;
                end
                tcmag_pkg::ST_TICK: begin
                    r_idle  <= !r_active;
                    r_ig    <= t_ig;
                    r_jg    <= t_jg;
                    r_kg    <= t_kg;
                    r_aok   <= (t_ig < r_rows) && (t_kg < r_depth);
                    r_bok   <= (t_jg < r_cols) && (t_kg < r_depth);
                    r_last  <= (16'(r_tbk) + 16'(r_tk)) >= 16'(r_depth);
                    r_cok   <= ((16'(r_tbk) + 16'(r_tk)) >= 16'(r_depth))
                               && (t_ig < r_rows) && (t_jg < r_cols);
                    r_dstep <= DSTEP_ROW;
                end
                tcmag_pkg::ST_DIV_WAIT: begin
                    if (i_div_rsp.done) begin
                        case (r_dstep)
                            DSTEP_ROW: begin
                                r_qh <= i_div_rsp.quot; r_rh <= i_div_rsp.rem;
                            end
                            DSTEP_KB: begin
                                r_q2 <= i_div_rsp.quot; r_r2 <= i_div_rsp.rem;
                            end
                            DSTEP_KW: begin
                                r_q3 <= i_div_rsp.quot; r_r3 <= i_div_rsp.rem;
                            end
                            default: r_r4 <= i_div_rsp.rem;
                        endcase
                        r_dstep <= r_dstep + 2'd1;
                    end
                end
                tcmag_pkg::ST_MUL1: begin
                    r_ih  <= m_ih[7:0];
                    r_iw  <= m_iw[7:0];
                    r_inb <= !m_ih[21] && (m_ih[20:0] < 21'(r_h))
                             && !m_iw[21] && (m_iw[20:0] < 21'(r_w));
                    r_ch  <= m_ch;
                    r_pc  <= 28'(r_ig) * 28'(r_cols);
                    r_mn  <= 28'(r_rows) * 28'(r_cols);
                    r_pb  <= 25'(r_jg) * 25'(r_depth);
                    r_pam <= 16'(r_im) * 16'(r_tk);
                    r_pbm <= 16'(r_ik) * 16'(r_tn);
                    r_jkb <= 16'(r_jg) * 16'(r_kb);
                end
                tcmag_pkg::ST_MUL2: begin
                    r_t <= 16'(r_ih) * 16'(r_w) + 16'(r_iw);
                end
                tcmag_pkg::ST_MUL3: begin
                    r_u <= 25'(r_t) * 25'(r_cin) + 25'(r_ch);
                end
                tcmag_pkg::ST_EMIT: begin
                    if (emit_ok) begin
                        r_wa    <= word_of(e_a);
                        r_ea    <= en_of(e_a);
                        r_wb    <= word_of(e_b);
                        r_eb    <= en_of(e_b);
                        r_wc    <= word_of(e_c);
                        r_ec    <= en_of(e_c);
                        r_run   <= !r_idle;
                        r_lastk <= !r_idle && r_last;
                        r_fin   <= !r_idle && n_done;
                        if (!r_idle) begin
                            r_im  <= n_im;
                            r_in  <= n_in;
                            r_ik  <= n_ik;
                            r_tbm <= n_tbm;
                            r_tbn <= n_tbn;
                            r_tbk <= n_tbk;
                            if (n_done) begin
                                r_active <= 1'b0;
                                r_coff   <= r_coff + AW'(r_mn);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.word_addr_a    = r_wa;
    assign o_res.enable_a       = r_ea;
    assign o_res.word_addr_b    = r_wb;
    assign o_res.enable_b       = r_eb;
    assign o_res.word_addr_c    = r_wc;
    assign o_res.enable_c       = r_ec;
    assign o_res.running        = r_run;
    assign o_res.last_k_tile    = r_lastk;
    assign o_res.layer_finished = r_fin;

endmodule

// ===== design/tiled_conv_matmul_address_generator_top.sv =====
// Top level of the tiled convolution / matmul address generator: configuration registers,
// command front end, shared divider and walk back end. Depends on tcmag_pkg, tcmag_if,
// tcmag_front, tcmag_div and tcmag_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   i_cmd   | in        | valid/ready        | command, clear_offset
//   o_res   | out       | valid/ready        | word_addr_a/b/c, enable_a/b/c, running,
//           |           |                    | last_k_tile, layer_finished
//   cfg     | in        | i_cfg_we (no wait) | i_cfg_idx, i_cfg_data
//
// Each command yields one result. A walk step is paced by the four back-to-back divisions
// of the single shared divider, which an idle tick skips; a start first passes through the
// latch and size states, which latch the layer and derive M, N and K. Commands queue two
// deep in front of the walker; a result waits in the output register while the next command
// is already being worked on, and the walker holds only when that register is still full.
// Reset (synchronous, active low) clears the registers, the queue, the walk counters and
// the running C offset; no clearing pass is needed.
module tiled_conv_matmul_address_generator_top #(
    parameter int ADDR_BITS = tcmag_pkg::ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    tcmag_cmd_if.sink                             i_cmd,
    tcmag_res_if.source                           o_res,
    input  logic                                  i_cfg_we,
    input  logic [tcmag_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tcmag_pkg::CFG_BITS-1:0]        i_cfg_data
);

    tcmag_pkg::t_cfg     r_cfg;
    tcmag_pkg::t_cmd     item;
    logic                item_valid;
    logic                item_pop;
    tcmag_pkg::t_div_req div_req;
    tcmag_pkg::t_div_rsp div_rsp;

    // register file; an index beyond the list is a no-op
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcmag_pkg::CFG_BASE_A:    r_cfg.base_a    <= i_cfg_data;
                tcmag_pkg::CFG_BASE_B:    r_cfg.base_b    <= i_cfg_data;
                tcmag_pkg::CFG_BASE_C:    r_cfg.base_c    <= i_cfg_data;
                tcmag_pkg::CFG_NULL_ADDR: r_cfg.null_addr <= i_cfg_data;
                tcmag_pkg::CFG_DIMS:      r_cfg.dims      <= i_cfg_data;
                tcmag_pkg::CFG_KERNEL:    r_cfg.kernel    <= i_cfg_data;
                tcmag_pkg::CFG_TILE_MODE: r_cfg.tile_mode <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // accept and queue commands
    tcmag_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    // shared divider for the im2col index split
    tcmag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // walk the tile loops and form the addresses
    tcmag_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_res        (o_res)
    );

endmodule

// ===== design/tcmag_checker.sv =====
// Port-level checks on the result channel of the address generator, bound to the top level.
// Depends on tcmag_pkg for widths; no other design files.
module tcmag_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [tcmag_pkg::WORD_BITS-1:0]   word_addr_a,
    input logic [tcmag_pkg::EN_BITS-1:0]     enable_a,
    input logic [tcmag_pkg::EN_BITS-1:0]     enable_b,
    input logic [tcmag_pkg::EN_BITS-1:0]     enable_c,
    input logic                              running,
    input logic                              last_k_tile,
    input logic                              layer_finished
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(word_addr_a) && $stable(running))
        else $error("result transfer dropped or changed while stalled");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> $onehot(enable_a) && $onehot(enable_b) && $onehot(enable_c))
        else $error("byte enable not one-hot");

    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && layer_finished |-> running)
        else $error("layer finished on an idle tick");

    a_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !running |-> !last_k_tile)
        else $error("last K tile flagged on an idle tick");

endmodule

bind tiled_conv_matmul_address_generator_top tcmag_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .res_valid      (o_res.valid),
    .res_ready      (o_res.ready),
    .word_addr_a    (o_res.word_addr_a),
    .enable_a       (o_res.enable_a),
    .enable_b       (o_res.enable_b),
    .enable_c       (o_res.enable_c),
    .running        (o_res.running),
    .last_k_tile    (o_res.last_k_tile),
    .layer_finished (o_res.layer_finished)
);
